### rtl/core/fsd_pkg.sv
// Package for the FNV-1a / splitmix64 digest block.
// Holds hash constants, configuration widths, request types and the sequencer states.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;
  localparam logic [63:0] WORD_SALT = 64'ha0761d6478bd642f;

  localparam int DEFAULT_MAX_DIGEST_BYTES = 64;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int DLEN_W     = 7;

  localparam logic [DLEN_W-1:0] DLEN_RESET = 7'd16;
  localparam logic [0:0] REG_DIGEST_LENGTH = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       final_byte;
  } out_req_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_FNV_MUL  = 7'b0000010,
    ST_MIX_ADD  = 7'b0000100,
    ST_MIX_MUL1 = 7'b0001000,
    ST_MIX_MUL2 = 7'b0010000,
    ST_MIX_FIN  = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

endpackage

### rtl/core/fnv1a_splitmix_digest_top.sv
// Top level of the FNV-1a-64 digest block with splitmix64 output expansion.
// Depends on fsd_pkg and fsd_mul64.
`timescale 1ns / 1ps

// Message bytes are absorbed one request at a time: a request without a byte and
// without last leaves the block idle, and a request carrying a byte waits in
// ST_FNV_MUL, since every 64-bit multiply runs through the single shared 32 x 32
// multiplier in fsd_mul64 over four steps. When a request marked last arrives, the
// block runs one splitmix64 round for the seed and one per 8-byte digest word, and
// delivers one digest byte per cycle while out_stall is low and no round is running.
// The block takes no new input request until the whole digest has been delivered.
// digest_length (address 0) sets the digest size and saturates at MAX_DIGEST_BYTES.
module fnv1a_splitmix_digest_top #(
  parameter int MAX_DIGEST_BYTES = fsd_pkg::DEFAULT_MAX_DIGEST_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fsd_pkg::in_req_t                in_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fsd_pkg::out_req_t               out_payload,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fsd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fsd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fsd_pkg::*;

  localparam int LEN_W = $clog2(MAX_DIGEST_BYTES + 1);

  state_t             state_r, state_nxt;
  logic [63:0]        hash_r, hash_nxt;
  logic [63:0]        count_r, count_nxt;
  logic [63:0]        v_r, v_nxt;
  logic [63:0]        s_r, s_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic               seed_r, seed_nxt;
  logic               go_r, go_nxt;
  logic [LEN_W-1:0]   k_r, k_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [DLEN_W-1:0]  digest_length_r;
  logic [LEN_W-1:0]   len_cfg;
  logic [LEN_W-1:0]   k_inc;
  logic [63:0]        mix_res;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               mul_done;
  logic [63:0]        mul_prod;
  logic               cfg_wr;

  fsd_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_DIGEST_LENGTH);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_DIGEST_LENGTH) ?
                  {{(CFG_DATA_W-DLEN_W){1'b0}}, digest_length_r} : '0;

  assign len_cfg = (digest_length_r > DLEN_W'(MAX_DIGEST_BYTES)) ?
                   LEN_W'(MAX_DIGEST_BYTES) : LEN_W'(digest_length_r);
  assign k_inc   = k_r + LEN_W'(1);
  assign mix_res = v_r ^ (v_r >> 31);

  always_comb begin
    unique case (state_r)
      ST_FNV_MUL: begin
        mul_a = hash_r ^ {56'h0, byte_r};
        mul_b = FNV_PRIME;
      end
      ST_MIX_MUL1: begin
        mul_a = v_r ^ (v_r >> 30);
        mul_b = SM_MUL1;
      end
      ST_MIX_MUL2: begin
        mul_a = v_r ^ (v_r >> 27);
        mul_b = SM_MUL2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    count_nxt = count_r;
    v_nxt     = v_r;
    s_nxt     = s_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    seed_nxt  = seed_r;
    go_nxt    = 1'b0;
    k_nxt     = k_r;
    len_nxt   = len_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_payload.data_byte;
          last_nxt = in_payload.last;
          if (in_payload.byte_present) begin
            state_nxt = ST_FNV_MUL;
            go_nxt    = 1'b1;
          end else if (in_payload.last) begin
            v_nxt     = count_r;
            seed_nxt  = 1'b1;
            state_nxt = ST_MIX_ADD;
          end
        end
      end
      ST_FNV_MUL: begin
        if (mul_done) begin
          hash_nxt  = mul_prod;
          count_nxt = count_r + 64'd1;
          if (last_r) begin
            v_nxt     = count_r + 64'd1;
            seed_nxt  = 1'b1;
            state_nxt = ST_MIX_ADD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MIX_ADD: begin
        v_nxt     = v_r + SM_GOLDEN;
        go_nxt    = 1'b1;
        state_nxt = ST_MIX_MUL1;
      end
      ST_MIX_MUL1: begin
        if (mul_done) begin
          v_nxt     = mul_prod;
          go_nxt    = 1'b1;
          state_nxt = ST_MIX_MUL2;
        end
      end
      ST_MIX_MUL2: begin
        if (mul_done) begin
          v_nxt     = mul_prod;
          state_nxt = ST_MIX_FIN;
        end
      end
      ST_MIX_FIN: begin
        if (seed_r) begin
          seed_nxt = 1'b0;
          k_nxt    = '0;
          len_nxt  = len_cfg;
          if (len_cfg == '0) begin
            hash_nxt  = FNV_BASIS;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            v_nxt     = hash_r ^ mix_res ^ WORD_SALT;
            state_nxt = ST_MIX_ADD;
          end
        end else begin
          s_nxt     = mix_res;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          k_nxt = k_inc;
          if (k_inc == len_r) begin
            hash_nxt  = FNV_BASIS;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else if (k_inc[2:0] == 3'd0) begin
            v_nxt     = s_r ^ WORD_SALT ^ 64'(k_inc);
            state_nxt = ST_MIX_ADD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      hash_r          <= FNV_BASIS;
      count_r         <= '0;
      seed_r          <= 1'b0;
      go_r            <= 1'b0;
      k_r             <= '0;
      len_r           <= '0;
      digest_length_r <= DLEN_RESET;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      count_r <= count_nxt;
      seed_r  <= seed_nxt;
      go_r    <= go_nxt;
      k_r     <= k_nxt;
      len_r   <= len_nxt;
      if (cfg_wr) begin
        digest_length_r <= pwdata[DLEN_W-1:0];
      end
    end
    v_r    <= v_nxt;
    s_r    <= s_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign in_stall                = (state_r != ST_IDLE);
  assign out_valid               = (state_r == ST_EMIT);
  assign out_payload.digest_byte = s_r[{k_r[2:0], 3'b000} +: 8];
  assign out_payload.final_byte  = (k_inc == len_r);

  a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input taken while a digest byte is pending");

  a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_payload.final_byte) |=> (!out_valid && !in_stall))
    else $error("block did not return to idle after the final digest byte");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (k_r < len_r))
    else $error("digest byte index beyond digest length");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_FNV_MUL || state_r == ST_MIX_MUL1 ||
                  state_r == ST_MIX_MUL2))
    else $error("multiplier finished outside a multiply state");

endmodule

### rtl/core/fsd_mul64.sv
// Iterative 64 x 64 multiplier that keeps the low 64 bits of the product.
// One shared 32 x 32 multiplier is used over four steps; depends on fsd_pkg.
`timescale 1ns / 1ps

module fsd_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] prod
);
  import fsd_pkg::*;

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mul_x;
  logic [31:0] mul_y;

  always_comb begin
    unique case (step_r)
      2'd1: begin
        mul_x = a_r[63:32];
        mul_y = b_r[31:0];
      end
      2'd2: begin
        mul_x = a_r[31:0];
        mul_y = b_r[63:32];
      end
      default: begin
        mul_x = a_r[31:0];
        mul_y = b_r[31:0];
      end
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      a_nxt    = op_a;
      b_nxt    = op_b;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_nxt    = {32'h0, mul_x} * {32'h0, mul_y};
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd1) begin
        acc_nxt = p_r;
      end else if (step_r != 2'd0) begin
        acc_nxt = acc_r + {p_r[31:0], 32'h0};
      end
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### test/testbench.sv
// Self-checking testbench for fnv1a_splitmix_digest_top: FNV-1a absorption and splitmix64 digest.
// A built-in predictor queues the expected digest bytes; random input idling and output stalls.
// Depends on fsd_pkg and the RTL of the digest block.
`timescale 1ns / 1ps

module testbench;
  import fsd_pkg::*;

  localparam int MAX_DIGEST = 64;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS = 150;

  localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic [63:0] DIGEST_SALT = 64'ha0761d6478bd642f;
  localparam logic [6:0] LEN_AT_RESET = 7'd16;

  localparam logic [fsd_pkg::CFG_ADDR_W-1:0] DLEN_ADDR = 3'd0;
  localparam logic [fsd_pkg::CFG_ADDR_W-1:0] UNUSED_ADDR = 3'd4;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_payload;
  logic out_valid;
  logic out_stall;
  out_req_t out_payload;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fsd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [fsd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [fsd_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [63:0] hash_state = HASH_BASIS;
  logic [63:0] byte_tally = '0;
  logic [6:0] digest_len = LEN_AT_RESET;
  out_req_t pending_digest[$];

  int mismatches = 0;
  int hold_request = 0;
  bit idle_on = 1'b1;

  fnv1a_splitmix_digest_top #(
    .MAX_DIGEST_BYTES(MAX_DIGEST)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload(out_payload),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] splitmix64(input logic [63:0] seed);
    logic [63:0] x;
    x = seed + MIX_GOLDEN;
    x = (x ^ (x >> 30)) * MIX_MUL_A;
    x = (x ^ (x >> 27)) * MIX_MUL_B;
    return x ^ (x >> 31);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, 40);
  endfunction

  // Absorbs one accepted request and, on last, queues the digest bytes it produces.
  task automatic absorb_and_digest(input in_req_t req);
    logic [63:0] seed;
    logic [63:0] k64;
    out_req_t digest;
    int n;
    int k;
    if (req.byte_present) begin
      hash_state = (hash_state ^ {56'd0, req.data_byte}) * HASH_PRIME;
      byte_tally = byte_tally + 64'd1;
    end
    if (req.last) begin
      n = (digest_len > MAX_DIGEST) ? MAX_DIGEST : int'(digest_len);
      seed = hash_state ^ splitmix64(byte_tally);
      for (k = 0; k < n; k++) begin
        k64 = 64'(k);
        if (k % 8 == 0) begin
          seed = splitmix64(seed ^ DIGEST_SALT ^ k64);
        end
        digest.digest_byte = seed[8 * (k % 8) +: 8];
        digest.final_byte = (k == n - 1);
        pending_digest = {pending_digest, digest};
      end
      hash_state = HASH_BASIS;
      byte_tally = '0;
    end
  endtask

  task automatic send_request(input logic [7:0] data_byte, input logic byte_present,
                              input logic last);
    in_req_t req;
    int gap;
    req.data_byte = data_byte;
    req.byte_present = byte_present;
    req.last = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (in_stall);
    absorb_and_digest(req);
  endtask

  task automatic send_message(input int nbytes, inout int items);
    int i;
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      items++;
    end
    send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    items++;
  endtask

  task automatic write_register(input logic [fsd_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [fsd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == DLEN_ADDR) begin
      digest_len = data[6:0];
    end
  endtask

  // The block may still be finishing a message that produces no bytes, so settle afterwards.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_messages();
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h01, 1'b1, 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_digest_lengths();
    logic [31:0] settings[8];
    int i;
    settings = '{32'd1, 32'd64, 32'd0, 32'd8, 32'd9, 32'd127, 32'd65, 32'hffffff8b};
    for (i = 0; i < 8; i++) begin
      drain();
      write_register(DLEN_ADDR, settings[i]);
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    drain();
    write_register(UNUSED_ADDR, 32'd3);
    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    int items;
    items = 0;
    drain();
    write_register(DLEN_ADDR, 32'd64);
    idle_on = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (3) send_message(2, items);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [31:0] wdata;
    int items;
    int pick;
    int msgs;
    int nbytes;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      drain();
      wdata = $urandom;
      if ($urandom_range(0, 3) != 0) begin
        wdata[31:7] = '0;
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          wdata[6:0] = 7'd1;
        end
        1: begin
          wdata[6:0] = 7'd64;
        end
        2: begin
          wdata[6:0] = 7'd0;
        end
        3: begin
          wdata[6:0] = 7'($urandom_range(65, 127));
        end
        default: begin
          wdata[6:0] = 7'($urandom_range(1, 64));
        end
      endcase
      write_register(DLEN_ADDR, wdata);
      idle_on = ($urandom_range(0, 3) != 0);
      msgs = $urandom_range(2, 5);
      repeat (msgs) begin
        nbytes = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        send_message(nbytes, items);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_stall
    int stall_left;
    int hold_left;
    int n;
    stall_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        n = pick_gap();
        out_stall <= (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    out_req_t expected;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digest.size() == 0) begin
        $error("unexpected digest byte %h", out_payload.digest_byte);
        mismatches++;
      end else begin
        expected = pending_digest.pop_front();
        if (out_payload.digest_byte !== expected.digest_byte) begin
          $error("digest_byte: expected %h, got %h", expected.digest_byte,
                 out_payload.digest_byte);
          mismatches++;
        end
        if (out_payload.final_byte !== expected.final_byte) begin
          $error("final_byte: expected %b, got %b", expected.final_byte,
                 out_payload.final_byte);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[fnv1a_splitmix_digest_top] ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_payload <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_messages();
    test_digest_lengths();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0 && pending_digest.size() == 0) begin
      $display("[fnv1a_splitmix_digest_top] OK");
    end else begin
      $display("[fnv1a_splitmix_digest_top] ERROR");
    end
    $finish;
  end

endmodule
